>>> rtl/pucsq_pkg.sv
package pucsq_pkg;

   localparam int NUM_CLASSES_DEF   = 8;
   localparam int URGENT_DEPTH_DEF  = 16;
   localparam int REGULAR_DEPTH_DEF = 16;

   localparam int HANDLE_W = 16;
   localparam int YEAR_W   = 16;
   localparam int ENTRY_W  = YEAR_W + HANDLE_W;
   localparam int COUNT_W  = 6;
   localparam int COUNT_MAX = (1 << COUNT_W) - 1;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                opcode;
      logic [2:0]          class_id;
      logic                urgent;
      logic [HANDLE_W-1:0] patient_handle;
      logic [YEAR_W-1:0]   seniority_year;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] served_handle;
      logic                served_urgent;
      logic [1:0]          status;
      logic [COUNT_W-1:0]  waiting_count;
   } rsp_type;

   // Control shared by every cell of the regular queue row.
   typedef struct packed {
      logic               insert;
      logic               wr_en;
      logic [ENTRY_W-1:0] new_entry;
   } cell_ctl_type;

endpackage

>>> rtl/per_class_urgent_then_seniority_queue_core.sv
// Per-class patient queue: each class has an urgent FIFO and a regular queue sorted by
// seniority year (ties leave in arrival order); a dequeue serves the urgent FIFO first.
// Every request passes three states: ST_IDLE accepts it, ST_READ does the registered read of
// the class's column in the cell row and the FIFO memory, and in ST_EXEC every cell shifts
// or keeps its entry in parallel and writes it back. The result is registered in ST_EXEC,
// and the next request can be accepted once the block is back in ST_IDLE. A new request is
// accepted while the previous result still waits in the output register; its ST_EXEC
// state then stalls until that result is taken.
module per_class_urgent_then_seniority_queue_core #(
   parameter int NUM_CLASSES   = pucsq_pkg::NUM_CLASSES_DEF,
   parameter int URGENT_DEPTH  = pucsq_pkg::URGENT_DEPTH_DEF,
   parameter int REGULAR_DEPTH = pucsq_pkg::REGULAR_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pucsq_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pucsq_pkg::rsp_type rsp_data
);

   localparam int CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int UFW = $clog2(URGENT_DEPTH + 1);
   localparam int HW  = $clog2(URGENT_DEPTH);
   localparam int RFW = $clog2(REGULAR_DEPTH + 1);
   localparam int SW  = ((UFW > RFW) ? UFW : RFW) + 1;
   localparam int AW  = (NUM_CLASSES * URGENT_DEPTH > 1) ?
                        $clog2(NUM_CLASSES * URGENT_DEPTH) : 1;
   localparam int EW  = pucsq_pkg::ENTRY_W;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EXEC} state_type;

   state_type          state_ff;
   pucsq_pkg::req_type req_ff;
   pucsq_pkg::rsp_type rsp_ff, rsp_in;
   logic               rsp_valid_ff;

   logic [UFW-1:0] ufill_ff [NUM_CLASSES];
   logic [HW-1:0]  uhead_ff [NUM_CLASSES];
   logic [RFW-1:0] rfill_ff [NUM_CLASSES];

   logic [UFW-1:0] ufill_in;
   logic [HW-1:0]  uhead_in;
   logic [RFW-1:0] rfill_in;

   logic [CW-1:0]  cls;
   logic           class_ok;
   logic [UFW-1:0] uf;
   logic [HW-1:0]  uh;
   logic [RFW-1:0] rf;
   logic [UFW:0]   slot_sum;
   logic [HW-1:0]  slot;
   logic [HW:0]    head_inc;
   logic [SW-1:0]  count_sum;
   logic           go;
   logic           fifo_wr;

   pucsq_pkg::cell_ctl_type ctl;
   logic [EW-1:0] cell_data [REGULAR_DEPTH];
   logic          cell_keep [REGULAR_DEPTH];
   logic [pucsq_pkg::HANDLE_W-1:0] fifo_rd;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign go        = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign cls      = CW'(req_ff.class_id);
   assign class_ok = int'(req_ff.class_id) < NUM_CLASSES;
   assign uf       = ufill_ff[cls];
   assign uh       = uhead_ff[cls];
   assign rf       = rfill_ff[cls];

   // Tail slot wraps once at most, so one compare and subtract is enough.
   assign slot_sum = (UFW + 1)'(uh) + (UFW + 1)'(uf);
   assign slot     = (slot_sum >= (UFW + 1)'(URGENT_DEPTH)) ?
                     HW'(slot_sum - (UFW + 1)'(URGENT_DEPTH)) : HW'(slot_sum);
   assign head_inc = (HW + 1)'(uh) + (HW + 1)'(1);

   always_comb begin
      rsp_in   = '0;
      ufill_in = uf;
      uhead_in = uh;
      rfill_in = rf;
      fifo_wr  = 1'b0;
      ctl.insert    = 1'b0;
      ctl.wr_en     = 1'b0;
      ctl.new_entry = {req_ff.seniority_year, req_ff.patient_handle};
      if (!class_ok) begin
         rsp_in.status = (req_ff.opcode == pucsq_pkg::OP_ENQUEUE) ?
                         pucsq_pkg::STATUS_FULL : pucsq_pkg::STATUS_EMPTY;
      end else if (req_ff.opcode == pucsq_pkg::OP_ENQUEUE) begin
         if (req_ff.urgent) begin
            if (uf < UFW'(URGENT_DEPTH)) begin
               fifo_wr  = go;
               ufill_in = uf + UFW'(1);
            end else begin
               rsp_in.status = pucsq_pkg::STATUS_FULL;
            end
         end else begin
            ctl.insert = 1'b1;
            if (rf < RFW'(REGULAR_DEPTH)) begin
               ctl.wr_en = go;
               rfill_in  = rf + RFW'(1);
            end else begin
               rsp_in.status = pucsq_pkg::STATUS_FULL;
            end
         end
      end else if (uf != '0) begin
         rsp_in.served_handle = fifo_rd;
         rsp_in.served_urgent = 1'b1;
         uhead_in = (head_inc == (HW + 1)'(URGENT_DEPTH)) ? '0 : HW'(head_inc);
         ufill_in = uf - UFW'(1);
      end else if (rf != '0) begin
         rsp_in.served_handle = cell_data[0][pucsq_pkg::HANDLE_W-1:0];
         ctl.wr_en = go;
         rfill_in  = rf - RFW'(1);
      end else begin
         rsp_in.status = pucsq_pkg::STATUS_EMPTY;
      end
      count_sum = SW'(ufill_in) + SW'(rfill_in);
      if (class_ok) begin
         rsp_in.waiting_count = (int'(count_sum) > pucsq_pkg::COUNT_MAX) ?
            pucsq_pkg::COUNT_W'(pucsq_pkg::COUNT_MAX) : pucsq_pkg::COUNT_W'(count_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            ufill_ff[i] <= '0;
            uhead_ff[i] <= '0;
            rfill_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready && !go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if (go) begin
                  rsp_ff       <= rsp_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  if (class_ok) begin
                     ufill_ff[cls] <= ufill_in;
                     uhead_ff[cls] <= uhead_in;
                     rfill_ff[cls] <= rfill_in;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   pucsq_ufifo #(
      .NUM_CLASSES  (NUM_CLASSES),
      .URGENT_DEPTH (URGENT_DEPTH)
   ) u_ufifo (
      .clock   (clock),
      .rd_addr (AW'(int'(cls) * URGENT_DEPTH + int'(uh))),
      .wr_en   (fifo_wr),
      .wr_addr (AW'(int'(cls) * URGENT_DEPTH + int'(slot))),
      .wr_data (req_ff.patient_handle),
      .rd_data (fifo_rd)
   );

   for (genvar j = 0; j < REGULAR_DEPTH; j++) begin : g_cell
      logic [EW-1:0] left_d, right_d;
      logic          left_k;
      if (j == 0) begin : g_first
         assign left_d = '0;
         assign left_k = 1'b1;
      end else begin : g_mid
         assign left_d = cell_data[j-1];
         assign left_k = cell_keep[j-1];
      end
      if (j == REGULAR_DEPTH - 1) begin : g_last
         assign right_d = cell_data[j];
      end else begin : g_next
         assign right_d = cell_data[j+1];
      end
      pucsq_cell #(
         .NUM_CLASSES   (NUM_CLASSES),
         .REGULAR_DEPTH (REGULAR_DEPTH),
         .POSITION      (j)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .addr       (cls),
         .fill       (rf),
         .left_data  (left_d),
         .left_keep  (left_k),
         .right_data (right_d),
         .data       (cell_data[j]),
         .keep       (cell_keep[j])
      );
   end

endmodule

>>> rtl/pucsq_cell.sv
module pucsq_cell #(
   parameter int NUM_CLASSES   = pucsq_pkg::NUM_CLASSES_DEF,
   parameter int REGULAR_DEPTH = pucsq_pkg::REGULAR_DEPTH_DEF,
   parameter int POSITION      = 0,
   localparam int CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
   localparam int RFW = $clog2(REGULAR_DEPTH + 1)
) (
   input  logic                               clock,
   input  pucsq_pkg::cell_ctl_type            ctl,
   input  logic [CW-1:0]                      addr,
   input  logic [RFW-1:0]                     fill,
   input  logic [pucsq_pkg::ENTRY_W-1:0]      left_data,
   input  logic                               left_keep,
   input  logic [pucsq_pkg::ENTRY_W-1:0]      right_data,
   output logic [pucsq_pkg::ENTRY_W-1:0]      data,
   output logic                               keep
);

   logic [pucsq_pkg::ENTRY_W-1:0] mem_ff [NUM_CLASSES];
   logic [pucsq_pkg::ENTRY_W-1:0] rd_ff;
   logic [pucsq_pkg::ENTRY_W-1:0] next_in;

   assign data = rd_ff;

   // An occupied entry whose year does not exceed the new year stays put.
   assign keep = (RFW'(POSITION) < fill) &&
                 (rd_ff[pucsq_pkg::ENTRY_W-1:pucsq_pkg::HANDLE_W] <=
                  ctl.new_entry[pucsq_pkg::ENTRY_W-1:pucsq_pkg::HANDLE_W]);

   always_comb begin
      if (!ctl.insert) begin
         next_in = right_data;
      end else if (keep) begin
         next_in = rd_ff;
      end else if (left_keep) begin
         next_in = ctl.new_entry;
      end else begin
         next_in = left_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem_ff[addr];
      if (ctl.wr_en) begin
         mem_ff[addr] <= next_in;
      end
   end

endmodule

>>> rtl/pucsq_ufifo.sv
module pucsq_ufifo #(
   parameter int NUM_CLASSES  = pucsq_pkg::NUM_CLASSES_DEF,
   parameter int URGENT_DEPTH = pucsq_pkg::URGENT_DEPTH_DEF,
   localparam int AW = (NUM_CLASSES * URGENT_DEPTH > 1) ?
                       $clog2(NUM_CLASSES * URGENT_DEPTH) : 1
) (
   input  logic                            clock,
   input  logic [AW-1:0]                   rd_addr,
   input  logic                            wr_en,
   input  logic [AW-1:0]                   wr_addr,
   input  logic [pucsq_pkg::HANDLE_W-1:0]  wr_data,
   output logic [pucsq_pkg::HANDLE_W-1:0]  rd_data
);

   logic [pucsq_pkg::HANDLE_W-1:0] mem_ff [NUM_CLASSES * URGENT_DEPTH];
   logic [pucsq_pkg::HANDLE_W-1:0] rd_ff;

   assign rd_data = rd_ff;

   always_ff @(posedge clock) begin
      rd_ff <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

endmodule

>>> verif/tb_top.sv
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCLS = pucsq_pkg::NUM_CLASSES_DEF;
   localparam int UDEP = pucsq_pkg::URGENT_DEPTH_DEF;
   localparam int RDEP = pucsq_pkg::REGULAR_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   pucsq_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   pucsq_pkg::rsp_type rsp_data;

   per_class_urgent_then_seniority_queue_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Shadow of the queue state, kept per class.
   logic [pucsq_pkg::HANDLE_W-1:0] urg_q[NCLS][$];
   logic [pucsq_pkg::ENTRY_W-1:0]  reg_q[NCLS][$];

   pucsq_pkg::rsp_type expected_rsp_q[$];
   int      mismatch_count;
   int      cycle_count;
   int      rsp_count;
   int      enq_count;
   int      deq_count;
   int      full_count;
   int      empty_count;
   bit      quiet_phase;

   typedef struct {
      pucsq_pkg::req_type req;
      bit                 has_fixed;
      pucsq_pkg::rsp_type fixed;
   } stim_row_type;

   function automatic pucsq_pkg::rsp_type predict_queue_step(pucsq_pkg::req_type r);
      pucsq_pkg::rsp_type            o;
      int                            c;
      int                            pos;
      logic [pucsq_pkg::ENTRY_W-1:0] e;
      o = '0;
      c = r.class_id;
      if (c >= NCLS) begin
         o.status = (r.opcode == pucsq_pkg::OP_ENQUEUE) ?
                    pucsq_pkg::STATUS_FULL : pucsq_pkg::STATUS_EMPTY;
         return o;
      end
      if (r.opcode == pucsq_pkg::OP_ENQUEUE) begin
         if (r.urgent) begin
            if (urg_q[c].size() < UDEP) urg_q[c].push_back(r.patient_handle);
            else o.status = pucsq_pkg::STATUS_FULL;
         end else if (reg_q[c].size() < RDEP) begin
            // Insert after every entry whose year is not larger, so ties keep arrival order.
            pos = reg_q[c].size();
            while (pos > 0 &&
                   reg_q[c][pos-1][pucsq_pkg::ENTRY_W-1:pucsq_pkg::HANDLE_W] >
                   r.seniority_year)
               pos--;
            reg_q[c].insert(pos, {r.seniority_year, r.patient_handle});
         end else begin
            o.status = pucsq_pkg::STATUS_FULL;
         end
      end else if (urg_q[c].size() > 0) begin
         o.served_handle = urg_q[c].pop_front();
         o.served_urgent = 1'b1;
      end else if (reg_q[c].size() > 0) begin
         e = reg_q[c].pop_front();
         o.served_handle = e[pucsq_pkg::HANDLE_W-1:0];
      end else begin
         o.status = pucsq_pkg::STATUS_EMPTY;
      end
      pos = urg_q[c].size() + reg_q[c].size();
      o.waiting_count = (pos > pucsq_pkg::COUNT_MAX) ?
                        pucsq_pkg::COUNT_W'(pucsq_pkg::COUNT_MAX) : pucsq_pkg::COUNT_W'(pos);
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d (response %0d)", what, got, want, rsp_count);
      mismatch_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result checker.
   always @(posedge clock) begin
      pucsq_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_data.served_handle, -1);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.served_handle !== want.served_handle)
               report_mismatch("served_handle", rsp_data.served_handle, want.served_handle);
            if (rsp_data.served_urgent !== want.served_urgent)
               report_mismatch("served_urgent", rsp_data.served_urgent, want.served_urgent);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.waiting_count !== want.waiting_count)
               report_mismatch("waiting_count", rsp_data.waiting_count, want.waiting_count);
         end
         rsp_count++;
      end
   end

   // Receiver stalls in bursts.
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 14);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Valid stays high from one request to the next unless an idle burst comes between.
   task automatic send_request(pucsq_pkg::req_type r, bit has_fixed,
                               pucsq_pkg::rsp_type fixed);
      pucsq_pkg::rsp_type want;
      int                 n;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      want = predict_queue_step(r);
      if (has_fixed) want = fixed;
      expected_rsp_q.push_back(want);
      if (r.opcode == pucsq_pkg::OP_ENQUEUE) enq_count++;
      else deq_count++;
      if (want.status == pucsq_pkg::STATUS_FULL) full_count++;
      if (want.status == pucsq_pkg::STATUS_EMPTY) empty_count++;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic pucsq_pkg::req_type make_req(bit op, int c, bit u, int h, int y);
      pucsq_pkg::req_type r;
      r.opcode         = op;
      r.class_id       = 3'(c);
      r.urgent         = u;
      r.patient_handle = pucsq_pkg::HANDLE_W'(h);
      r.seniority_year = pucsq_pkg::YEAR_W'(y);
      return r;
   endfunction

   function automatic pucsq_pkg::rsp_type make_rsp(int h, bit u, logic [1:0] s, int w);
      pucsq_pkg::rsp_type o;
      o.served_handle = pucsq_pkg::HANDLE_W'(h);
      o.served_urgent = u;
      o.status        = s;
      o.waiting_count = pucsq_pkg::COUNT_W'(w);
      return o;
   endfunction

   initial begin
      stim_row_type       rows[$];
      pucsq_pkg::req_type r;
      int                 c;
      int                 mode;
      int                 wait_cycles;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      rsp_count      = 0;
      enq_count      = 0;
      deq_count      = 0;
      full_count     = 0;
      empty_count    = 0;
      quiet_phase    = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: empty classes, extremes, urgent before regular, year ties.
      rows.push_back('{make_req(pucsq_pkg::OP_DEQUEUE, 0, 0, 0, 0), 1,
                       make_rsp(0, 0, pucsq_pkg::STATUS_EMPTY, 0)});
      rows.push_back('{make_req(pucsq_pkg::OP_DEQUEUE, 7, 1, 16'hFFFF, 16'hFFFF), 1,
                       make_rsp(0, 0, pucsq_pkg::STATUS_EMPTY, 0)});
      rows.push_back('{make_req(pucsq_pkg::OP_ENQUEUE, 7, 0, 16'hFFFF, 16'hFFFF), 1,
                       make_rsp(0, 0, pucsq_pkg::STATUS_OK, 1)});
      rows.push_back('{make_req(pucsq_pkg::OP_ENQUEUE, 7, 0, 16'h1234, 16'h0000), 1,
                       make_rsp(0, 0, pucsq_pkg::STATUS_OK, 2)});
      rows.push_back('{make_req(pucsq_pkg::OP_ENQUEUE, 7, 0, 16'h0001, 16'h0000), 0, '0});
      rows.push_back('{make_req(pucsq_pkg::OP_ENQUEUE, 7, 1, 16'hAAAA, 16'h5555), 0, '0});
      for (int i = 0; i < 5; i++)
         rows.push_back('{make_req(pucsq_pkg::OP_DEQUEUE, 7, 0, 0, 0), 0, '0});
      // Fill one class's urgent FIFO past its depth, then dequeue two entries from it.
      for (int i = 0; i <= UDEP; i++)
         rows.push_back('{make_req(pucsq_pkg::OP_ENQUEUE, 3, 1, 16'h8000 + i, 0), 0, '0});
      for (int i = 0; i < 2; i++)
         rows.push_back('{make_req(pucsq_pkg::OP_DEQUEUE, 3, 1, 0, 0), 0, '0});

      foreach (rows[i]) send_request(rows[i].req, rows[i].has_fixed, rows[i].fixed);

      // Random part: phases that favor filling, draining, or an even mix of enqueues and dequeues.
      for (int i = 0; i < 600; i++) begin
         if (i % 100 == 0) mode = $urandom_range(0, 2);
         if (i >= 520) quiet_phase = 1'b1;
         c = (i % 50 < 35) ? $urandom_range(0, 1) : $urandom_range(0, 7);
         r = make_req(pucsq_pkg::OP_ENQUEUE, c, 1'($urandom_range(0, 1)), $urandom, $urandom);
         case (mode)
            0: r.opcode = ($urandom_range(0, 9) < 7) ? pucsq_pkg::OP_ENQUEUE
                                                     : pucsq_pkg::OP_DEQUEUE;
            1: r.opcode = ($urandom_range(0, 9) < 3) ? pucsq_pkg::OP_ENQUEUE
                                                     : pucsq_pkg::OP_DEQUEUE;
            default: r.opcode = 1'($urandom_range(0, 1));
         endcase
         // Narrow year range makes ties frequent.
         if ($urandom_range(0, 1)) r.seniority_year = pucsq_pkg::YEAR_W'($urandom_range(0, 3));
         send_request(r, 0, '0);
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (expected_rsp_q.size() != 0 && wait_cycles < 10000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);

      $display("covered %0d enqueues and %0d dequeues, %0d full and %0d empty outcomes",
               enq_count, deq_count, full_count, empty_count);
      $display("%0d responses checked", rsp_count);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/pucsq_pkg.sv
rtl/pucsq_cell.sv
rtl/pucsq_ufifo.sv
rtl/per_class_urgent_then_seniority_queue_core.sv
verif/tb_top.sv
